// ----- hdl/assert_macros.svh -----
// Assertion macros for the span fill checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/dhsf_pkg.sv -----
// Shared types, constants and the color rotation function of the span fill unit.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package dhsf_pkg;

	localparam int unsigned Columns = 40;
	localparam int unsigned Rows = 192;
	localparam logic [14:0] PageBase = 15'h4000;

	typedef logic [5:0] col_t;
	typedef logic [6:0] rng_t;
	typedef logic [6:0] pat_t;
	typedef logic [14:0] addr_t;

	// Everything the column sweep needs, captured once per command.
	typedef struct packed {
		rng_t a_lo;
		rng_t a_hi;
		rng_t m_lo;
		rng_t m_hi;
		logic a_ok;
		logic m_ok;
		logic go;
		col_t col_first;
		col_t col_last;
		addr_t base;
		pat_t [3:0] pat;
	} span_t;

	// One write produced by the shared column unit.
	typedef struct packed {
		logic aw;
		logic mw;
		logic is_last;
		pat_t aux_d;
		pat_t main_d;
		addr_t addr;
	} beat_t;

	// Pattern j has bit k equal to color bit ((k - j) mod 4).
	function automatic pat_t rotate_pattern(input logic [3:0] nib, input logic [1:0] j);
		pat_t v;
		logic [1:0] src;
		v = '0;
		for (int k = 0; k < 7; k++) begin
			src = 2'(k) - j;
			v[k] = nib[src];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/dhsf_setup.sv -----
// Command decode: bank column ranges, scanline base address and color patterns.
// Depends on dhsf_pkg; the result is registered when a command is accepted.
`default_nettype none

module dhsf_setup (
	input  wire logic            clk,
	input  wire logic            load,
	input  wire logic [6:0]      group_first,
	input  wire logic [6:0]      group_last,
	input  wire logic [7:0]      row,
	input  wire logic [3:0]      color,
	output dhsf_pkg::span_t      span
);
	import dhsf_pkg::*;

	localparam rng_t LastCol = rng_t'(Columns - 1);

	rng_t  a_lo, a_hi, m_lo, m_hi;
	rng_t  a_top, m_top, lo_sel, hi_sel;
	logic  m_any, a_ok, m_ok;
	addr_t band_off;
	span_t span_d, span_q;

	// Even groups map to aux columns, odd groups to main columns.
	always_comb begin
		a_lo  = {1'b0, group_first[6:1]} + {6'b0, group_first[0]};
		a_hi  = {1'b0, group_last[6:1]};
		m_lo  = {1'b0, group_first[6:1]};
		m_any = (group_last != '0);
		if (group_last[0]) begin
			m_hi = {1'b0, group_last[6:1]};
		end else if (m_any) begin
			m_hi = {1'b0, group_last[6:1]} - 7'd1;
		end else begin
			m_hi = '0;
		end
		a_ok  = (a_lo <= a_hi) && (a_lo <= LastCol);
		m_ok  = m_any && (m_lo <= m_hi) && (m_lo <= LastCol);
		a_top = (a_hi > LastCol) ? LastCol : a_hi;
		m_top = (m_hi > LastCol) ? LastCol : m_hi;
	end

	// The sweep runs from the lowest covered column to the highest one.
	always_comb begin
		if (a_ok && m_ok) begin
			lo_sel = (a_lo < m_lo) ? a_lo : m_lo;
			hi_sel = (a_top > m_top) ? a_top : m_top;
		end else if (a_ok) begin
			lo_sel = a_lo;
			hi_sel = a_top;
		end else begin
			lo_sel = m_lo;
			hi_sel = m_top;
		end
	end

	// Interleaved scanline base: row bits 2:0 pick the 1K block, bits 5:3 the
	// 128-byte line, and the top two bits one of three 40-byte bands.
	always_comb begin
		band_off = {8'b0, row[7:6], 5'b0} + {10'b0, row[7:6], 3'b0};
		span_d.a_lo      = a_lo;
		span_d.a_hi      = a_hi;
		span_d.m_lo      = m_lo;
		span_d.m_hi      = m_hi;
		span_d.a_ok      = a_ok;
		span_d.m_ok      = m_ok;
		span_d.go        = (row < 8'(Rows)) && (a_ok || m_ok);
		span_d.col_first = lo_sel[5:0];
		span_d.col_last  = hi_sel[5:0];
		span_d.base      = (PageBase | {2'b0, row[2:0], row[5:3], 7'b0}) + band_off;
		for (int j = 0; j < 4; j++) begin
			span_d.pat[j] = rotate_pattern(color, 2'(j));
		end
	end

	// Command register, loaded on each accepted transfer.
	always_ff @(posedge clk) begin
		if (load) begin
			span_q <= span_d;
		end
	end

	assign span = span_q;

endmodule

`default_nettype wire

// ----- hdl/dhsf_col_unit.sv -----
// Shared column unit: range compares, pattern select and address add.
// Depends on dhsf_pkg; used once per cycle by the sweep sequencer.
`default_nettype none

module dhsf_col_unit (
	input  wire dhsf_pkg::span_t span,
	input  wire dhsf_pkg::col_t  col,
	output dhsf_pkg::beat_t      beat
);
	import dhsf_pkg::*;

	rng_t col_ext;

	// Bank enables come from the two column ranges; a disabled bank writes zero.
	always_comb begin
		col_ext      = {1'b0, col};
		beat.aw      = span.a_ok && (col_ext >= span.a_lo) && (col_ext <= span.a_hi);
		beat.mw      = span.m_ok && (col_ext >= span.m_lo) && (col_ext <= span.m_hi);
		beat.aux_d   = beat.aw ? span.pat[{col[0], 1'b0}] : '0;
		beat.main_d  = beat.mw ? span.pat[{col[0], 1'b1}] : '0;
		beat.addr    = span.base + {9'b0, col};
		beat.is_last = (col == span.col_last);
	end

endmodule

`default_nettype wire

// ----- hdl/double_hires_span_fill_unit.sv -----
// Top level of the double high-resolution span fill unit.
// Depends on dhsf_pkg, dhsf_setup and dhsf_col_unit.
//
// Usage:
// A command (group_first, group_last, row, color) is transferred at a rising
// edge where start is high and busy is low. busy then stays high until the
// sweep over the covered columns is finished.
// Each write leaves on address, aux_write, aux_data, main_write, main_data and
// last, valid for exactly one cycle while strobe is high; the receiver cannot
// stall, so every strobed write is taken. last marks the final write.
// Sweep: the command is decoded in the check state, then the single column
// unit visits one column per cycle from the lowest to the highest covered
// column, so a command covers at most 40 columns.
// The first write leaves the output register after the check state and the
// first run-state column, and writes follow back to back. A command with an empty
// span or a row beyond the screen produces no writes; the check state returns to idle.
// Reset returns the sequencer to idle and clears strobe; no state carries
// over between commands.
`default_nettype none

module double_hires_span_fill_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [6:0]   group_first,
	input  wire logic [6:0]   group_last,
	input  wire logic [7:0]   row,
	input  wire logic [3:0]   color,
	output logic              strobe,
	output logic [14:0]       address,
	output logic              aux_write,
	output logic [6:0]        aux_data,
	output logic              main_write,
	output logic [6:0]        main_data,
	output logic              last
);
	import dhsf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CHECK = 3'b010,
		ST_RUN   = 3'b100
	} state_t;

	state_t state_q;
	col_t   col_q;
	span_t  span;
	beat_t  beat;
	logic   load;
	logic   strobe_q;
	addr_t  address_q;
	logic   aux_write_q, main_write_q, last_q;
	pat_t   aux_data_q, main_data_q;

	assign busy = (state_q != ST_IDLE);
	assign load = start && !busy;

	dhsf_setup u_setup (
		.clk         (clk),
		.load        (load),
		.group_first (group_first),
		.group_last  (group_last),
		.row         (row),
		.color       (color),
		.span        (span)
	);

	dhsf_col_unit u_col (
		.span (span),
		.col  (col_q),
		.beat (beat)
	);

	// Sweep sequencer: decode, then step the column until the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			col_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_RUN) && (beat.aw || beat.mw);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (span.go) begin
						col_q   <= span.col_first;
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RUN: begin
					col_q <= col_q + 6'd1;
					if (beat.is_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register for the write of the current column.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			address_q    <= beat.addr;
			aux_write_q  <= beat.aw;
			aux_data_q   <= beat.aux_d;
			main_write_q <= beat.mw;
			main_data_q  <= beat.main_d;
			last_q       <= beat.is_last;
		end
	end

	assign strobe     = strobe_q;
	assign address    = address_q;
	assign aux_write  = aux_write_q;
	assign aux_data   = aux_data_q;
	assign main_write = main_write_q;
	assign main_data  = main_data_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// ----- hdl/dhsf_checker.sv -----
// Port-level checker for the span fill unit, bound to the top level.
// Depends on dhsf_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dhsf_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        strobe,
	input  wire logic [14:0] address,
	input  wire logic        aux_write,
	input  wire logic [6:0]  aux_data,
	input  wire logic        main_write,
	input  wire logic [6:0]  main_data,
	input  wire logic        last
);
	import dhsf_pkg::*;

	// A command transfer always makes the block busy in the next cycle.
	`ASSERT_NXT(a_take_busy, clk, arst_n, start && !busy, busy)

	// A write that is not the last of its command comes while still busy.
	`ASSERT_IMP(a_mid_busy, clk, arst_n, strobe && !last, busy)

	// Every strobed write enables at least one bank within page two.
	`ASSERT_IMP(a_bank_on, clk, arst_n, strobe, (aux_write || main_write) && (address >= PageBase))

	// A disabled bank carries a zero byte.
	`ASSERT_IMP(a_zero_data, clk, arst_n, strobe, (aux_write || aux_data == '0) && (main_write || main_data == '0))

	// The final write is never followed directly by another one.
	`ASSERT_NXT(a_last_gap, clk, arst_n, strobe && last, !strobe)

endmodule

bind double_hires_span_fill_unit dhsf_checker u_dhsf_checker (.*);

`default_nettype wire
